>>> src/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// types and constants shared by the bit set engine modules
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_FLIP  = 3'd2;
  localparam logic [2:0] OP_TEST  = 3'd3;
  localparam logic [2:0] OP_INV   = 3'd4;

  localparam logic [7:0] TOP_BIT  = 8'h80;
  localparam logic [7:0] BYTE_ALL = 8'hFF;
  localparam logic [2:0] POS_MASK = 3'h7;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] bit_index;
  } in_word_t;

  typedef struct packed {
    logic        bit_value;
    logic        out_of_range;
    logic [10:0] population;
    logic        any_set;
    logic [9:0]  first_index;
    logic [9:0]  last_index;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic go;
    logic rd;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic len_zero;
    logic rd_last;
  } dp_stat_t;

endpackage

>>> src/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bse_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// sequencer: clearing pass after reset, then, unless no byte is in use, one scan pass per word
// ----------------------------------------------------------------------------
module bse_ctrl
  import bse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = stat.len_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.rd_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy   = 1'b0;
        cmd.go = start;
      end
      ST_SCAN:  cmd.rd = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

>>> src/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// byte store, read-modify-write scan and result accumulators
// ----------------------------------------------------------------------------
module bse_dp
  import bse_pkg::*;
#(
  parameter int SET_BITS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  output dp_stat_t   stat,
  input  in_word_t   in_word,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int STORE_BYTES = SET_BITS / 8;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LEN_W       = $clog2(STORE_BYTES + 1);
  localparam int LEN_RST     = (STORE_BYTES < 128) ? STORE_BYTES : 128;

  logic [LEN_W-1:0] len_r;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [2:0]       op_r;
  logic [9:0]       idx_r;
  logic             oor_r;
  logic             proc_vld_r;
  logic [AW-1:0]    proc_addr_r;
  logic [10:0]      pop_r, pop_nxt;
  logic             found_r, found_nxt;
  logic [9:0]       first_r, first_nxt;
  logic [9:0]       last_r, last_nxt;
  logic             bitval_r, bitval_nxt;

  logic [31:0]      cfg_ext;
  logic [7:0]       rd_data;
  logic [7:0]       new_byte;
  logic [7:0]       mask;
  logic             is_tgt;
  logic             go_oor;
  logic [2:0]       fj, lj;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = {24'd0, cfg_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(LEN_RST);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= (cfg_ext > 32'(STORE_BYTES)) ? LEN_W'(STORE_BYTES) : LEN_W'(cfg_ext);
    end
  end

  assign stat.clr_last = (32'(cnt_r) == 32'(STORE_BYTES - 1));
  assign stat.len_zero = (len_r == '0);
  assign stat.rd_last  = ((32'(cnt_r) + 32'd1) == 32'(len_r));

  assign go_oor = (32'(in_word.bit_index[9:3]) >= 32'(len_r));
  assign mask   = TOP_BIT >> (idx_r & {7'd0, POS_MASK});
  assign is_tgt = !oor_r && (32'(proc_addr_r) == 32'(idx_r[9:3]));

  // modify the byte that just came out of the store
  always_comb begin
    new_byte = rd_data;
    if (op_r == OP_INV) begin
      new_byte = rd_data ^ BYTE_ALL;
    end else if (is_tgt) begin
      case (op_r)
        OP_SET:   new_byte = rd_data | mask;
        OP_CLEAR: new_byte = rd_data & (mask ^ BYTE_ALL);
        OP_FLIP:  new_byte = rd_data ^ mask;
        default:  new_byte = rd_data;
      endcase
    end
  end

  // msb-first positions of the first and last set bit in the byte
  always_comb begin
    fj = '0;
    lj = '0;
    for (int j = 7; j >= 0; j--) begin
      if (new_byte[7-j]) fj = 3'(j);
    end
    for (int j = 0; j < 8; j++) begin
      if (new_byte[7-j]) lj = 3'(j);
    end
  end

  always_comb begin
    pop_nxt    = pop_r;
    found_nxt  = found_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    bitval_nxt = bitval_r;
    if (proc_vld_r) begin
      pop_nxt = pop_r + 11'($countones(new_byte));
      if (new_byte != 8'd0) begin
        found_nxt = 1'b1;
        last_nxt  = 10'((32'(proc_addr_r) << 3) | 32'(lj));
        if (!found_r) begin
          first_nxt = 10'((32'(proc_addr_r) << 3) | 32'(fj));
        end
      end
      if (is_tgt) begin
        bitval_nxt = |(new_byte & mask);
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.go) begin
      cnt_nxt = '0;
    end else if (cmd.clr_wr || cmd.rd) begin
      cnt_nxt = stat.clr_last ? '0 : cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      proc_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    proc_addr_r <= cnt_r;
    if (cmd.go) begin
      op_r     <= in_word.op;
      idx_r    <= in_word.bit_index;
      oor_r    <= go_oor;
      pop_r    <= '0;
      found_r  <= 1'b0;
      first_r  <= '0;
      last_r   <= '0;
      bitval_r <= 1'b0;
    end else begin
      pop_r    <= pop_nxt;
      found_r  <= found_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      bitval_r <= bitval_nxt;
    end
  end

  assign wr_en   = cmd.clr_wr || proc_vld_r;
  assign wr_addr = cmd.clr_wr ? cnt_r : proc_addr_r;
  assign wr_data = cmd.clr_wr ? 8'd0 : new_byte;

  bse_ram #(
    .WIDTH  (8),
    .DEPTH  (STORE_BYTES),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  assign out_word.bit_value    = bitval_r;
  assign out_word.out_of_range = oor_r;
  assign out_word.population   = pop_r;
  assign out_word.any_set      = found_r;
  assign out_word.first_index  = first_r;
  assign out_word.last_index   = last_r;

endmodule

>>> src/bit_set_engine.sv
// ----------------------------------------------------------------------------
// bit_set_engine
// bit vector with set/clear/flip/test/invert, popcount and first/last scan
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Each word makes one
// pass over the bytes in use, one byte per cycle through the store's single
// read port with the modified byte written back in the following cycle. The
// result is shown after the scan and a drain state, or with no scan when no
// byte is in use, and the next word can be taken in the cycle after the result.
// The result is shown for one cycle with out_valid and cannot be held off.
// After reset the store is cleared one byte per cycle, busy staying high until
// every byte is cleared. cfg_ready is always high; write cfg_data only while
// idle. Values above SET_BITS/8 are clamped.
module bit_set_engine
  import bse_pkg::*;
#(
  parameter int SET_BITS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_word_t   in_word,
  output logic       out_valid,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bse_dp #(
    .SET_BITS (SET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

>>> src/bse_checker.sv
// ----------------------------------------------------------------------------
// bse_checker
// port-level checks on the bit set engine, bound to the top level
// ----------------------------------------------------------------------------
module bse_checker
  import bse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after a word was taken");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("not idle after result");

  a_oor_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.out_of_range) |-> !out_word.bit_value)
    else $error("bit value set on an out of range index");

endmodule

bind bit_set_engine bse_checker u_bse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bit_set_engine: random and directed bit operations
// under several byte spans and sender idle rates, every result word checked
// against a local model of the bit vector and its scans
// ----------------------------------------------------------------------------
module tb;
  import bse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_BITS    = 1024;
  localparam int STORE_BYTES = SET_BITS / 8;
  localparam int LIMIT       = 1000000;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_word_t   in_word   = '0;
  logic       out_valid;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  in_word_t   pending[$];
  out_word_t  expected[$];
  logic [7:0] mirror[STORE_BYTES];
  int         span     = STORE_BYTES;
  int         idle_pct = 0;
  int         errors   = 0;
  int         cycles   = 0;

  bit_set_engine #(.SET_BITS(SET_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // apply one word to the local copy of the vector and scan the bytes in use
  function automatic out_word_t apply_word(in_word_t w);
    int unsigned len;
    int unsigned byte_no;
    int unsigned pop;
    logic [7:0]  mask;
    out_word_t   r;
    bit          hit;
    len     = (span > STORE_BYTES) ? STORE_BYTES : span;
    byte_no = w.bit_index >> 3;
    mask    = TOP_BIT >> w.bit_index[2:0];
    r       = '0;
    hit     = 1'b0;
    pop     = 0;
    r.out_of_range = (byte_no >= len);
    if (w.op == OP_INV) begin
      for (int i = 0; i < len; i++) mirror[i] = mirror[i] ^ BYTE_ALL;
    end else if (!r.out_of_range) begin
      case (w.op)
        OP_SET:   mirror[byte_no] = mirror[byte_no] | mask;
        OP_CLEAR: mirror[byte_no] = mirror[byte_no] & ~mask;
        OP_FLIP:  mirror[byte_no] = mirror[byte_no] ^ mask;
        default: ;
      endcase
    end
    if (!r.out_of_range) r.bit_value = |(mirror[byte_no] & mask);
    for (int i = 0; i < len; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (mirror[i][7-j]) begin
          if (!hit) r.first_index = 10'(i * 8 + j);
          r.last_index = 10'(i * 8 + j);
          hit = 1'b1;
          pop++;
        end
      end
    end
    r.population = 11'(pop);
    r.any_set    = hit;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned len;
    int unsigned pick;
    len  = (span > STORE_BYTES) ? STORE_BYTES : span;
    pick = $urandom_range(99);
    if (pick < 3)       w.op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    else if (pick < 10) w.op = OP_INV;
    else                w.op = 3'($urandom_range(OP_TEST, OP_SET));
    if (len == 0 || $urandom_range(99) < 20) w.bit_index = 10'($urandom_range(SET_BITS - 1));
    else                                       w.bit_index = 10'($urandom_range(len * 8 - 1));
    return w;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected.push_back(apply_word(in_word));
      if (!start || !busy) begin
        if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= pending.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected.size() == 0) begin
        flag_mismatch("unexpected word", 1, 0);
      end else begin
        automatic out_word_t want = expected.pop_front();
        if (out_word.bit_value !== want.bit_value)
          flag_mismatch("bit_value", out_word.bit_value, want.bit_value);
        if (out_word.out_of_range !== want.out_of_range)
          flag_mismatch("out_of_range", out_word.out_of_range, want.out_of_range);
        if (out_word.population !== want.population)
          flag_mismatch("population", out_word.population, want.population);
        if (out_word.any_set !== want.any_set)
          flag_mismatch("any_set", out_word.any_set, want.any_set);
        if (out_word.first_index !== want.first_index)
          flag_mismatch("first_index", out_word.first_index, want.first_index);
        if (out_word.last_index !== want.last_index)
          flag_mismatch("last_index", out_word.last_index, want.last_index);
      end
    end
  end

  task automatic wait_quiet(int tail);
    do @(negedge clk);
    while (pending.size() != 0 || start || busy || expected.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_span(int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 8'(value);
    do @(posedge clk);
    while (!cfg_ready);
    span      = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_word(logic [2:0] op, int idx);
    in_word_t w;
    w.op        = op;
    w.bit_index = 10'(idx);
    pending.push_back(w);
  endtask

  initial begin
    int phase_span[15]  = '{4, 1, 16, 2, 128, 0, 255, 9, 64, 3, 130, 32, 5, 7, 12};
    int phase_items[15] = '{150, 100, 150, 100, 60, 40, 50, 150, 80, 150, 50, 120, 150,
                            120, 110};
    int idle_steps[3]   = '{0, 46, 36};
    foreach (mirror[i]) mirror[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_quiet(2);

    // full span from reset: empty scans, both ends, invert, spare op codes
    push_word(OP_TEST, 0);
    push_word(OP_SET, 0);
    push_word(OP_SET, SET_BITS - 1);
    push_word(OP_TEST, SET_BITS - 1);
    push_word(OP_FLIP, 7);
    push_word(OP_FLIP, 8);
    push_word(OP_CLEAR, 0);
    push_word(OP_TEST, 512);
    push_word(OP_INV, 0);
    push_word(OP_TEST, 8);
    push_word(OP_CLEAR, SET_BITS - 1);
    push_word(OP_FLIP, SET_BITS - 1);
    push_word(OP_INV, SET_BITS - 1);
    push_word(OP_UNUSED_FIRST, 7);
    push_word(OP_UNUSED_FIRST + 3'd1, 8);
    push_word(OP_UNUSED_LAST, SET_BITS - 1);
    wait_quiet(4);

    // one byte in use, then none, then a value above the store size
    write_span(1);
    push_word(OP_SET, SET_BITS - 1);
    push_word(OP_SET, 7);
    push_word(OP_INV, 3);
    push_word(OP_TEST, 8);
    wait_quiet(4);
    write_span(0);
    push_word(OP_SET, 0);
    push_word(OP_INV, 0);
    push_word(OP_TEST, 0);
    wait_quiet(4);
    write_span(255);
    push_word(OP_TEST, SET_BITS - 1);
    push_word(OP_INV, 0);
    wait_quiet(4);

    for (int p = 0; p < 15; p++) begin
      write_span(phase_span[p]);
      idle_pct = idle_steps[p % 3];
      for (int k = 0; k < phase_items[p]; k++) pending.push_back(random_word());
      wait_quiet(4);
    end

    wait_quiet(STORE_BYTES + 16);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> bit_set_engine.f
src/bse_pkg.sv
src/bse_ram.sv
src/bse_ctrl.sv
src/bse_dp.sv
src/bit_set_engine.sv
src/bse_checker.sv
dv/tb.sv
